// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is low.
`define FBM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Check that a signal keeps its value in the cycle after a condition.
`define FBM_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
  `FBM_ASSERT(lbl, clk, rst_n, (cond) |=> $stable(sig))

`endif

// File: rtl/fbm_pkg.sv
// Package with types, codes and defaults of the free-block MRU list.
`timescale 1ns / 1ps
package fbm_pkg;

  localparam int unsigned SLOTS_DEF      = 8;
  localparam int unsigned ADDR_WIDTH_DEF = 32;
  localparam int unsigned FIELD_ADDR_W   = 32;
  localparam int unsigned COUNT_W        = 4;

  typedef enum logic [1:0] {
    FUNC_APPEND  = 2'd0,
    FUNC_REMOVE  = 2'd1,
    FUNC_REPLACE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY,
    ST_FINISH
  } state_e;

  // Sequencer controls toward the datapath.
  typedef struct packed {
    logic rotate;
    logic search;
    logic apply;
    logic last;
    logic finish;
  } seq_t;

endpackage

// File: rtl/fbm_in_if.sv
// Request channel interface: operation and addresses.
`timescale 1ns / 1ps
interface fbm_in_if;
  import fbm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic [FIELD_ADDR_W-1:0] entry_addr;
  logic [FIELD_ADDR_W-1:0] old_addr;

  modport source (output valid, output func, output entry_addr, output old_addr,
                  input ready);
  modport sink   (input valid, input func, input entry_addr, input old_addr,
                  output ready);
endinterface

// File: rtl/fbm_out_if.sv
// Result channel interface: match flag, dropped entry, count and head.
`timescale 1ns / 1ps
interface fbm_out_if;
  import fbm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic                    dropped_valid;
  logic [FIELD_ADDR_W-1:0] dropped_addr;
  logic [COUNT_W-1:0]      entry_count;
  logic [FIELD_ADDR_W-1:0] head_addr;

  modport source (output valid, output found, output dropped_valid,
                  output dropped_addr, output entry_count, output head_addr,
                  input ready);
  modport sink   (input valid, input found, input dropped_valid,
                  input dropped_addr, input entry_count, input head_addr,
                  output ready);
endinterface

// File: rtl/fbm_ring.sv
// Slot storage as a rotating ring with taps at the two front slots.
`timescale 1ns / 1ps
module fbm_ring #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rotate_i,
  input  logic [ADDR_WIDTH-1:0] wr_data_i,
  output logic [ADDR_WIDTH-1:0] head_o,
  output logic [ADDR_WIDTH-1:0] tap1_o
);

  logic [ADDR_WIDTH-1:0] slot_q [SLOTS];

  // Advance every slot one place toward the front, feed the tail.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_q[i] <= '0;
      end
    end else if (rotate_i) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        slot_q[i] <= slot_q[i+1];
      end
      slot_q[SLOTS-1] <= wr_data_i;
    end
  end

  assign head_o = slot_q[0];
  assign tap1_o = slot_q[1];

endmodule

// File: rtl/fbm_ctrl.sv
// Sequencer: search and apply passes over the ring, one slot per cycle.
`timescale 1ns / 1ps
module fbm_ctrl #(
  parameter int unsigned SLOTS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         need_search_i,
  input  logic         out_free_i,
  output logic         in_ready_o,
  output fbm_pkg::seq_t seq_o
);
  import fbm_pkg::*;

  localparam int unsigned StepW = $clog2(SLOTS);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             last;

  assign last = (step_q == StepW'(SLOTS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = need_search_i ? ST_SEARCH : ST_APPLY;
        end
      end
      ST_SEARCH: begin
        if (last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    seq_o      = '0;
    seq_o.last = last;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SEARCH: begin
        seq_o.rotate = 1'b1;
        seq_o.search = 1'b1;
      end
      ST_APPLY: begin
        seq_o.rotate = 1'b1;
        seq_o.apply  = 1'b1;
      end
      ST_FINISH: seq_o.finish = 1'b1;
      default:   in_ready_o = 1'b0;
    endcase
  end

  // Count slots within a pass; wrap at the last one.
  always_comb begin
    step_d = step_q;
    if (seq_o.rotate) begin
      step_d = last ? '0 : step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// File: rtl/free_block_mru_list_unit.sv
// Top level of the free-block MRU list: request and result channels, datapath.
`timescale 1ns / 1ps
// Keeps up to SLOTS free-block addresses, newest first, packed at the front;
// zero marks an empty slot and the list is empty after reset. func selects
// append (push at the front, push out the last entry of a full list),
// remove (take out the first match, close the gap) or replace (take out the
// first match of old_addr, put entry_addr at the front); code 3 does
// nothing. A zero search address never matches and a zero entry_addr is
// refused. The slots sit in a ring that turns one place per cycle past a
// single comparator; a request takes one turn of the ring, and a replace
// with a nonzero entry_addr takes one extra turn to search first.
// The request channel is ready only between requests; the result register
// lets a new request start while the previous result waits for transfer.
module free_block_mru_list_unit #(
  parameter int unsigned SLOTS      = fbm_pkg::SLOTS_DEF,
  parameter int unsigned ADDR_WIDTH = fbm_pkg::ADDR_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbm_in_if.sink     in_i,
  fbm_out_if.source  out_o
);
  import fbm_pkg::*;

  localparam int unsigned CountW = $clog2(SLOTS + 1);

  // Sequencer
  seq_t seq;
  logic in_ready;
  logic start;
  logic need_search;
  logic out_free;

  // Request capture
  logic [ADDR_WIDTH-1:0] ea_in, oa_in;
  func_e                 op_q;
  logic [ADDR_WIDTH-1:0] ea_q, key_q;

  // Ring and working state
  logic [ADDR_WIDTH-1:0] ring_head, ring_tap1, ring_wr;
  logic [ADDR_WIDTH-1:0] carry_q, carry_d;
  logic                  match_q, match_d;
  logic                  found_q, found_d;
  logic                  cmp_hit;
  logic [CountW-1:0]     count_q, count_next;

  // Result register
  logic                    out_valid_q;
  logic                    res_found_q, res_found;
  logic                    res_dvalid_q, res_dvalid;
  logic [FIELD_ADDR_W-1:0] res_daddr_q;
  logic [COUNT_W-1:0]      res_count_q;
  logic [FIELD_ADDR_W-1:0] res_head_q;

  // Only the low ADDR_WIDTH bits of an address take part.
  assign ea_in = ADDR_WIDTH'(in_i.entry_addr);
  assign oa_in = ADDR_WIDTH'(in_i.old_addr);

  assign start       = in_i.valid && in_ready;
  assign need_search = (in_i.func == FUNC_REPLACE) && (ea_in != '0);
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = in_ready;

  fbm_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .need_search_i (need_search),
    .out_free_i    (out_free),
    .in_ready_o    (in_ready),
    .seq_o         (seq)
  );

  fbm_ring #(
    .SLOTS      (SLOTS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rotate_i  (seq.rotate),
    .wr_data_i (ring_wr),
    .head_o    (ring_head),
    .tap1_o    (ring_tap1)
  );

  // Capture the request; remove searches entry_addr, replace old_addr.
  always_ff @(posedge clk_i) begin
    if (start) begin
      op_q  <= func_e'(in_i.func);
      ea_q  <= ea_in;
      key_q <= (in_i.func == FUNC_REPLACE) ? oa_in : ea_in;
    end
  end

  // The one shared comparator: front slot against the search key.
  assign cmp_hit = (ring_head == key_q) && (key_q != '0);

  // Per-slot step of a pass. By default the front slot goes back to the
  // tail unchanged, so a full turn restores the list.
  always_comb begin
    ring_wr = ring_head;
    carry_d = carry_q;
    match_d = match_q;
    found_d = found_q;
    if (start) begin
      carry_d = ea_in;
      match_d = 1'b0;
      found_d = 1'b0;
    end else if (seq.search) begin
      if (cmp_hit) begin
        found_d = 1'b1;
      end
    end else if (seq.apply) begin
      case (op_q)
        FUNC_APPEND: begin
          // Delay the stream by one slot; the new address leads.
          if (ea_q != '0) begin
            ring_wr = carry_q;
            carry_d = ring_head;
          end
        end
        FUNC_REMOVE: begin
          // From the match on, take the next slot; empty the last one.
          if (match_q || cmp_hit) begin
            match_d = 1'b1;
            ring_wr = seq.last ? '0 : ring_tap1;
          end
        end
        FUNC_REPLACE: begin
          // Delay the stream up to and including the match, then copy.
          if (found_q && !match_q) begin
            ring_wr = carry_q;
            carry_d = ring_head;
            if (cmp_hit) begin
              match_d = 1'b1;
            end
          end
        end
        default: ring_wr = ring_head;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  // Result of the finished pass; the ring head is the new front slot.
  always_comb begin
    res_found  = 1'b0;
    res_dvalid = 1'b0;
    count_next = count_q;
    case (op_q)
      FUNC_APPEND: begin
        if (ea_q != '0) begin
          res_found = 1'b1;
          if (count_q == CountW'(SLOTS)) begin
            res_dvalid = 1'b1;
          end else begin
            count_next = count_q + CountW'(1);
          end
        end
      end
      FUNC_REMOVE: begin
        if (match_q) begin
          res_found  = 1'b1;
          count_next = count_q - CountW'(1);
        end
      end
      FUNC_REPLACE: res_found = found_q;
      default:      res_found = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q     <= 1'b0;
      found_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      match_q <= match_d;
      found_q <= found_d;
      if (seq.finish && out_free) begin
        count_q     <= count_next;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result only when the previous one has been transferred.
  always_ff @(posedge clk_i) begin
    if (seq.finish && out_free) begin
      res_found_q  <= res_found;
      res_dvalid_q <= res_dvalid;
      res_daddr_q  <= res_dvalid ? FIELD_ADDR_W'(carry_q) : '0;
      res_count_q  <= COUNT_W'(count_next);
      res_head_q   <= FIELD_ADDR_W'(ring_head);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.found         = res_found_q;
  assign out_o.dropped_valid = res_dvalid_q;
  assign out_o.dropped_addr  = res_daddr_q;
  assign out_o.entry_count   = res_count_q;
  assign out_o.head_addr     = res_head_q;

endmodule

// File: rtl/fbm_checker.sv
// Port-level checker for the free-block MRU list, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        found_i,
  input logic        dropped_valid_i,
  input logic [31:0] dropped_addr_i,
  input logic [3:0]  entry_count_i,
  input logic [31:0] head_addr_i
);

  // Hold a pending result until its transfer.
  `FBM_ASSERT_HOLD(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `FBM_ASSERT(a_out_payload_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> ($stable(found_i) && $stable(dropped_valid_i) && $stable(dropped_addr_i) && $stable(entry_count_i) && $stable(head_addr_i)))

  // A request keeps the block busy: ready drops in the cycle after it is taken.
  `FBM_ASSERT(a_busy_after_req, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i)

  // Only a carried-out append pushes an entry out.
  `FBM_ASSERT(a_drop_needs_found, clk_i, rst_ni, (out_valid_i && dropped_valid_i) |-> found_i)
  `FBM_ASSERT(a_drop_addr_zero, clk_i, rst_ni, (out_valid_i && !dropped_valid_i) |-> (dropped_addr_i == 32'd0))

endmodule

bind free_block_mru_list_unit fbm_checker u_fbm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .found_i         (out_o.found),
  .dropped_valid_i (out_o.dropped_valid),
  .dropped_addr_i  (out_o.dropped_addr),
  .entry_count_i   (out_o.entry_count),
  .head_addr_i     (out_o.head_addr)
);

// File: tb/tb_top.sv
// Self-checking testbench for the free-block MRU list unit.
`timescale 1ns / 1ps
module tb_top;
  import fbm_pkg::*;

  localparam int unsigned MRU_SLOTS  = SLOTS_DEF;
  localparam int unsigned MRU_AW     = 32;
  // Function code with no operation behind it; the block must answer it anyway.
  localparam logic [1:0]  FUNC_NONE  = 2'd3;
  localparam int unsigned RAND_REQS  = 1800;
  localparam int unsigned POOL_DEPTH = 16;
  // Slowest request (replace) holds the block longest: a search turn, then an apply turn.
  localparam int unsigned DRAIN_CYC  = 2 * MRU_SLOTS + 12;
  // Worst run: ~1830 requests, each with busy time, longest sender gap and receiver stall.
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]        op;
    logic [MRU_AW-1:0] entry;
    logic [MRU_AW-1:0] old;
  } list_req_t;

  typedef struct {
    logic              found;
    logic              dropped_valid;
    logic [MRU_AW-1:0] dropped_addr;
    logic [3:0]        entry_count;
    logic [MRU_AW-1:0] head_addr;
  } list_result_t;

  logic clk_i;
  logic rst_ni;

  fbm_in_if  req_if ();
  fbm_out_if res_if ();

  free_block_mru_list_unit #(
    .SLOTS      (MRU_SLOTS),
    .ADDR_WIDTH (MRU_AW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // Requests still to be sent, and the answers the list model predicts for
  // requests the block has already taken.
  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];

  // Shadow copy of the slot array: nonzero addresses packed at the front.
  logic [MRU_AW-1:0] mru_slots[MRU_SLOTS];

  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned result_cnt;
  int unsigned found_cnt;
  int unsigned drop_cnt;
  int unsigned sent_cnt;

  logic req_fire;
  int   gap_left;
  int   stall_left;
  logic send_quiet;
  logic recv_quiet;

  // Clock: 8 ns period.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Drive every input to a known value from time zero; hold reset low, then
  // release it at a falling edge.
  initial begin
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.func        = FUNC_APPEND;
    req_if.entry_addr  = '0;
    req_if.old_addr    = '0;
    res_if.ready       = 1'b0;
    req_fire           = 1'b0;
    gap_left           = 0;
    stall_left         = 0;
    send_quiet         = 1'b0;
    recv_quiet         = 1'b0;
    cycle_cnt          = 0;
    mismatch_cnt       = 0;
    result_cnt         = 0;
    found_cnt          = 0;
    drop_cnt           = 0;
    sent_cnt           = 0;
    for (int i = 0; i < MRU_SLOTS; i++) mru_slots[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Apply one request to the shadow list and return the answer it must give.
  // A search only ever matches occupied slots, so a zero search address fails,
  // and a zero address to insert is refused without touching the list.
  function automatic list_result_t mru_apply(input logic [1:0] op,
                                             input logic [MRU_AW-1:0] entry,
                                             input logic [MRU_AW-1:0] old);
    list_result_t res;
    int           pos;
    int unsigned  cnt;
    res = '{found: 1'b0, dropped_valid: 1'b0, dropped_addr: '0,
            entry_count: '0, head_addr: '0};
    pos = MRU_SLOTS;
    cnt = 0;
    case (op)
      FUNC_APPEND: begin
        if (entry != '0) begin
          res.found = 1'b1;
          // First empty slot; scan from the back so the lowest index wins.
          for (int i = MRU_SLOTS - 1; i >= 0; i--) if (mru_slots[i] == '0) pos = i;
          if (pos == MRU_SLOTS) begin
            res.dropped_valid = 1'b1;
            res.dropped_addr  = mru_slots[MRU_SLOTS-1];
            pos               = MRU_SLOTS - 1;
          end
          for (int i = pos; i > 0; i--) mru_slots[i] = mru_slots[i-1];
          mru_slots[0] = entry;
        end
      end
      FUNC_REMOVE: begin
        if (entry != '0)
          for (int i = MRU_SLOTS - 1; i >= 0; i--) if (mru_slots[i] == entry) pos = i;
        if (pos < MRU_SLOTS) begin
          res.found = 1'b1;
          // Close the gap and clear the last slot.
          for (int i = pos; i < MRU_SLOTS - 1; i++) mru_slots[i] = mru_slots[i+1];
          mru_slots[MRU_SLOTS-1] = '0;
        end
      end
      FUNC_REPLACE: begin
        if (old != '0)
          for (int i = MRU_SLOTS - 1; i >= 0; i--) if (mru_slots[i] == old) pos = i;
        if (pos < MRU_SLOTS && entry != '0) begin
          res.found = 1'b1;
          // Entries in front of the match move back one place; the old one goes.
          for (int i = pos; i > 0; i--) mru_slots[i] = mru_slots[i-1];
          mru_slots[0] = entry;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < MRU_SLOTS; i++) if (mru_slots[i] != '0) cnt++;
    res.entry_count = cnt[3:0];
    res.head_addr   = mru_slots[0];
    return res;
  endfunction

  task automatic add_req(input logic [1:0] op, input logic [MRU_AW-1:0] entry,
                         input logic [MRU_AW-1:0] old);
    list_req_t r;
    r.op    = op;
    r.entry = entry;
    r.old   = old;
    pending_reqs.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [MRU_AW-1:0] exp_val,
                             input logic [MRU_AW-1:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_cnt++;
      $display("%0t: result %0d %s mismatch: expected 0x%08h, got 0x%08h",
               $time, result_cnt, name, exp_val, act_val);
    end
  endtask

  // Request driver: present the next pending request at a falling edge, hold
  // it until the block takes it, then idle for a random gap.
  always @(negedge clk_i) begin
    list_req_t nxt;
    if (rst_ni) begin
      if (!req_if.valid || req_fire) begin
        if (gap_left > 0) begin
          req_if.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          req_if.valid      <= 1'b1;
          req_if.func       <= nxt.op;
          req_if.entry_addr <= nxt.entry;
          req_if.old_addr   <= nxt.old;
          gap_left          <= send_quiet ? 0 : pick_gap();
          // Switch now and then into a stretch without any gaps.
          if ($urandom_range(0, 59) == 0) send_quiet <= !send_quiet;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: stall at random, with quiet stretches where ready stays high.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        res_if.ready <= 1'b1;
        if (!recv_quiet && $urandom_range(0, 99) < 30) stall_left <= pick_gap() + 1;
        if ($urandom_range(0, 199) == 0) recv_quiet <= !recv_quiet;
      end
    end
  end

  // Monitor: on each rising edge predict for an accepted request and check an
  // accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (!rst_ni) begin
      req_fire <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      req_fire  <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        sent_cnt <= sent_cnt + 1;
        expected_results.push_back(mru_apply(req_if.func, req_if.entry_addr,
                                             req_if.old_addr));
      end
      if (res_if.valid && res_if.ready) begin
        if (res_if.found) found_cnt <= found_cnt + 1;
        if (res_if.dropped_valid) drop_cnt <= drop_cnt + 1;
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with nothing expected: found %0b count %0d head 0x%08h",
                   $time, res_if.found, res_if.entry_count, res_if.head_addr);
        end else begin
          exp_res = expected_results.pop_front();
          check_field("found", exp_res.found, res_if.found);
          check_field("dropped_valid", exp_res.dropped_valid, res_if.dropped_valid);
          check_field("dropped_addr", exp_res.dropped_addr, res_if.dropped_addr);
          check_field("entry_count", exp_res.entry_count, res_if.entry_count);
          check_field("head_addr", exp_res.head_addr, res_if.head_addr);
        end
        result_cnt++;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still expected",
               $time, cycle_cnt, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [MRU_AW-1:0] addr_pool[POOL_DEPTH];
    int unsigned       pool_used;
    int unsigned       append_w;
    int unsigned       remove_lim;
    int unsigned       r;
    logic [1:0]        op;
    logic [MRU_AW-1:0] entry;
    logic [MRU_AW-1:0] old;

    // Directed part: empty-list corner cases first.
    add_req(FUNC_APPEND,  32'h0000_0000, 32'h0000_0000); // insert zero: refused
    add_req(FUNC_REMOVE,  32'h0000_0000, 32'hFFFF_FFFF); // search for zero
    add_req(FUNC_NONE,    32'h1234_5678, 32'h8765_4321); // unused code, empty list
    add_req(FUNC_REMOVE,  32'h0000_0005, 32'h0000_0000); // not found on empty list
    // Fill the list with extreme addresses and a duplicate, then overflow it.
    add_req(FUNC_APPEND,  32'hFFFF_FFFF, 32'h0000_0000);
    add_req(FUNC_APPEND,  32'h0000_0001, 32'hFFFF_FFFF);
    add_req(FUNC_APPEND,  32'h8000_0000, 32'h0000_0000);
    add_req(FUNC_APPEND,  32'h7FFF_FFFF, 32'h0000_0000);
    add_req(FUNC_APPEND,  32'hAAAA_AAAA, 32'h0000_0000);
    add_req(FUNC_APPEND,  32'h5555_5555, 32'h0000_0000);
    add_req(FUNC_APPEND,  32'h1234_5678, 32'h0000_0000);
    add_req(FUNC_APPEND,  32'h0000_0001, 32'h0000_0000); // duplicate, list now full
    add_req(FUNC_APPEND,  32'hCAFE_F00D, 32'h0000_0000); // pushes out the oldest
    add_req(FUNC_REMOVE,  32'h0000_0001, 32'h0000_0000); // first of two matches
    add_req(FUNC_REPLACE, 32'h0BAD_0BAD, 32'h0000_0000); // search for zero
    add_req(FUNC_REPLACE, 32'h0000_0000, 32'hAAAA_AAAA); // insert zero: refused
    add_req(FUNC_REPLACE, 32'hDEAD_BEEF, 32'h0000_0001); // match near the back
    add_req(FUNC_REPLACE, 32'hFFFF_FFFF, 32'hDEAD_BEEF); // match at the front
    add_req(FUNC_REMOVE,  32'h0000_0BAD, 32'h0000_0000); // not found
    add_req(FUNC_NONE,    32'hFFFF_FFFF, 32'hFFFF_FFFF); // unused code, busy list
    add_req(FUNC_REMOVE,  32'h7FFF_FFFF, 32'h0000_0000);
    add_req(FUNC_APPEND,  32'h0000_0002, 32'h0000_0000);

    // Random part: addresses mostly come from a small pool so that searches
    // hit; the mix of operations shifts every block to fill and drain the list.
    pool_used = 0;
    append_w  = 40;
    for (int n = 0; n < RAND_REQS; n++) begin
      if (n % 150 == 0) begin
        for (int i = 0; i < POOL_DEPTH; i++) begin
          addr_pool[i] = $urandom;
          if (addr_pool[i] == '0) addr_pool[i] = 32'h0000_0001;
        end
        pool_used = $urandom_range(4, POOL_DEPTH);
      end
      if (n % 100 == 0) append_w = $urandom_range(20, 70);
      remove_lim = append_w + (95 - append_w) / 2;

      r = $urandom_range(0, 99);
      if (r < append_w)        op = FUNC_APPEND;
      else if (r < remove_lim) op = FUNC_REMOVE;
      else if (r < 95)         op = FUNC_REPLACE;
      else                     op = FUNC_NONE;

      r = $urandom_range(0, 99);
      if (r < 4)       entry = '0;
      else if (r < 12) entry = $urandom;
      else             entry = addr_pool[$urandom_range(0, pool_used - 1)];

      r = $urandom_range(0, 99);
      if (op != FUNC_REPLACE || r < 10) old = $urandom;
      else if (r < 14)                  old = '0;
      else                              old = addr_pool[$urandom_range(0, pool_used - 1)];

      add_req(op, entry, old);
    end

    // Drain: all requests taken, every prediction answered, then a quiet tail.
    while (!rst_ni || pending_reqs.size() != 0 || req_if.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      mismatch_cnt++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end

    $display("Ran %0d list requests over %0d cycles; %0d results checked,",
             sent_cnt, cycle_cnt, result_cnt);
    $display("  %0d with a match or insert, %0d pushing out an entry, %0d mismatches",
             found_cnt, drop_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
